[sv/bfha_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and command codes of the best-fit heap allocator.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
package bfha_pkg;

  // Heap geometry
  localparam int unsigned HEAP_BYTES = 4096;
  localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
  localparam int unsigned WADDR_W    = $clog2(HEAP_WORDS);
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned ADDR_W     = WORD_W + 1;   // byte offset with room for a carry
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned REQ_W      = 13;
  localparam int unsigned NEED_W     = REQ_W + 1;

  localparam logic [ADDR_W-1:0] END_AT    = ADDR_W'(HEAP_BYTES - 4);
  localparam logic [ADDR_W-1:0] FIRST_AT  = ADDR_W'(4);
  localparam logic [WORD_W-1:0] TAIL_WORD = WORD_W'(1);
  localparam logic [WORD_W-1:0] INIT_SIZE = WORD_W'(HEAP_BYTES - 8);

  // Request codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  // Datapath commands
  typedef enum logic [4:0] {
    DP_NOP,
    DP_INIT_HDR,
    DP_INIT_FTR,
    DP_INIT_END,
    DP_START,
    DP_RD_POS,
    DP_ALLOC_STEP,
    DP_RD_NXT,
    DP_LATCH_NV,
    DP_AW1,
    DP_AW2,
    DP_AW3,
    DP_FREE_STEP,
    DP_LATCH_H,
    DP_RD_FNX,
    DP_NV_RDPS,
    DP_LATCH_PS,
    DP_FW1,
    DP_FW2,
    DP_FW3,
    DP_OUT_OK,
    DP_OUT_FAIL
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_func;    // func of the word on the input channel
    logic req_zero;   // allocate of zero bytes
    logic free_bad;   // free offset out of range or misaligned
    logic pos_end;    // walk position at or past the end mark
    logic hstop;      // header read is the end mark or a zero size
    logic hit;        // walk position equals the header to free
    logic past;       // walk position beyond the header to free
    logic h_used;     // used bit of the header just read
    logic found;      // a fitting free block was found
    logic split;      // remainder of the chosen block is at least 8 bytes
    logic nx_keep;    // next block is used and not the end mark
  } dp_status_t;

endpackage

[sv/bfha_if.sv]
`timescale 1ns / 1ps
// Request and response channels of the allocator, valid/ready handshake.
// Depends on bfha_pkg for field widths.
interface bfha_req_if import bfha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [REQ_W-1:0]   request_bytes;
  logic [OFF_W-1:0]   free_offset;

  modport source (output valid, func, request_bytes, free_offset, input ready);
  modport sink   (input valid, func, request_bytes, free_offset, output ready);
endinterface

interface bfha_rsp_if import bfha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [OFF_W-1:0]   granted_offset;

  modport source (output valid, status, granted_offset, input ready);
  modport sink   (input valid, status, granted_offset, output ready);
endinterface

[sv/bfha_dp.sv]
`timescale 1ns / 1ps
// Datapath of the allocator: heap memory, walk registers, address and value arithmetic.
// Depends on bfha_pkg; driven by bfha_ctrl through dp_cmd_t, reports through dp_status_t.
module bfha_dp import bfha_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  logic               func_i,
  input  logic [REQ_W-1:0]   request_bytes_i,
  input  logic [OFF_W-1:0]   free_offset_i,
  output dp_status_t         status_o,
  output logic               out_status_o,
  output logic [OFF_W-1:0]   out_offset_o
);

  logic [WORD_W-1:0] mem_q [HEAP_WORDS];
  logic [WORD_W-1:0] rdata_q;

  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [OFF_W-1:0]  hdr_q, hdr_d, best_q, best_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [WORD_W-1:0] bsize_q, bsize_d, bhdr_q, bhdr_d, nv_q, nv_d, h_q, h_d, ps_q, ps_d;
  logic              found_q, found_d, func_q, func_d;
  logic              out_status_q, out_status_d;
  logic [OFF_W-1:0]  out_offset_q, out_offset_d;

  logic [WORD_W-1:0] sz, rem, t, ns, nxt_add, accum, ps_sel, ns_sel;
  logic [ADDR_W-1:0] best_a, hdr_a, best_end, f_ext;
  logic [NEED_W-1:0] need_raw;
  logic              pfree, nend, nfree, fit;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  // Decoded fields of the latched words
  assign sz       = {rdata_q[WORD_W-1:2], 2'b00};
  assign rem      = bsize_q - WORD_W'(need_q);
  assign t        = {h_q[WORD_W-1:2], 2'b00};
  assign ns       = {nv_q[WORD_W-1:2], 2'b00};
  assign pfree    = ~h_q[1];
  assign nend     = (nv_q == TAIL_WORD);
  assign nfree    = ~nend & ~nv_q[0];
  assign nxt_add  = nv_q[0] ? '0 : nv_q;
  assign ps_sel   = pfree ? ps_q : '0;
  assign ns_sel   = nfree ? ns : '0;
  assign accum    = ps_sel + t + ns_sel;
  assign best_a   = ADDR_W'(best_q);
  assign hdr_a    = ADDR_W'(hdr_q);
  assign best_end = best_a + ADDR_W'(bsize_q);
  assign f_ext    = ADDR_W'(free_offset_i);
  assign need_raw = NEED_W'(request_bytes_i) + NEED_W'(11);
  assign fit      = ~rdata_q[0] && (sz >= WORD_W'(need_q)) && (!found_q || sz < bsize_q);

  // Status towards the controller
  always_comb begin
    status_o.in_func  = func_i;
    status_o.req_zero = (request_bytes_i == '0);
    status_o.free_bad = (free_offset_i < OFF_W'(8)) || (free_offset_i[2:0] != 3'd0) ||
                        ((f_ext - ADDR_W'(4)) >= END_AT);
    status_o.pos_end  = (pos_q >= END_AT);
    status_o.hstop    = (rdata_q == TAIL_WORD) || (sz == '0);
    status_o.hit      = (pos_q == hdr_a);
    status_o.past     = (pos_q > hdr_a);
    status_o.h_used   = rdata_q[0];
    status_o.found    = found_q;
    status_o.split    = (rem >= WORD_W'(8));
    status_o.nx_keep  = ~nfree & ~nend;
  end

  // Command decode: register updates and memory access
  always_comb begin
    pos_d        = pos_q;
    hdr_d        = hdr_q;
    best_d       = best_q;
    need_d       = need_q;
    bsize_d      = bsize_q;
    bhdr_d       = bhdr_q;
    nv_d         = nv_q;
    h_d          = h_q;
    ps_d         = ps_q;
    found_d      = found_q;
    func_d       = func_q;
    out_status_d = out_status_q;
    out_offset_d = out_offset_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = pos_q;
    mem_wdata    = '0;
    unique case (cmd_i.op)
      DP_NOP: ;
      DP_INIT_HDR: begin
        mem_we    = 1'b1;
        mem_addr  = FIRST_AT;
        mem_wdata = INIT_SIZE + WORD_W'(2);
      end
      DP_INIT_FTR: begin
        mem_we    = 1'b1;
        mem_addr  = ADDR_W'(INIT_SIZE);
        mem_wdata = INIT_SIZE;
      end
      DP_INIT_END: begin
        mem_we    = 1'b1;
        mem_addr  = END_AT;
        mem_wdata = TAIL_WORD;
      end
      DP_START: begin
        func_d  = func_i;
        need_d  = {need_raw[NEED_W-1:3], 3'b000};
        pos_d   = FIRST_AT;
        found_d = 1'b0;
        hdr_d   = free_offset_i - OFF_W'(4);
      end
      DP_RD_POS: begin
        mem_re   = 1'b1;
        mem_addr = pos_q;
      end
      DP_ALLOC_STEP: begin
        if (fit) begin
          found_d = 1'b1;
          best_d  = pos_q[OFF_W-1:0];
          bsize_d = sz;
          bhdr_d  = rdata_q;
        end
        pos_d = pos_q + ADDR_W'(sz);
      end
      DP_RD_NXT: begin
        mem_re   = 1'b1;
        mem_addr = best_end;
      end
      DP_LATCH_NV: nv_d = rdata_q;
      DP_AW1: begin
        mem_we    = 1'b1;
        mem_addr  = best_a;
        mem_wdata = status_o.split ? (bhdr_q - rem + WORD_W'(1)) : (bhdr_q | WORD_W'(1));
      end
      DP_AW2: begin
        if (status_o.split) begin
          mem_we    = 1'b1;
          mem_addr  = best_a + ADDR_W'(need_q);
          mem_wdata = rem + WORD_W'(2) + nxt_add;
        end else begin
          // exact fit: mark the following real block's previous-used bit
          mem_we    = (nv_q != TAIL_WORD) && (best_end < END_AT);
          mem_addr  = best_end;
          mem_wdata = nv_q | WORD_W'(2);
        end
      end
      DP_AW3: begin
        mem_we    = 1'b1;
        mem_addr  = best_end - ADDR_W'(4) + ADDR_W'(nxt_add);
        mem_wdata = rem + nxt_add;
      end
      DP_FREE_STEP: pos_d = pos_q + ADDR_W'(sz);
      DP_LATCH_H:   h_d = rdata_q;
      DP_RD_FNX: begin
        mem_re   = 1'b1;
        mem_addr = hdr_a + ADDR_W'(t);
      end
      DP_NV_RDPS: begin
        nv_d     = rdata_q;
        mem_re   = 1'b1;
        mem_addr = hdr_a - ADDR_W'(4);
      end
      DP_LATCH_PS: ps_d = rdata_q;
      DP_FW1: begin
        mem_we    = 1'b1;
        mem_addr  = hdr_a - ADDR_W'(ps_sel);
        mem_wdata = accum + WORD_W'(2);
      end
      DP_FW2: begin
        mem_we    = 1'b1;
        mem_addr  = hdr_a + ADDR_W'(t) + ADDR_W'(ns_sel) - ADDR_W'(4);
        mem_wdata = accum;
      end
      DP_FW3: begin
        mem_we    = 1'b1;
        mem_addr  = hdr_a + ADDR_W'(t);
        mem_wdata = nv_q & ~WORD_W'(2);
      end
      DP_OUT_OK: begin
        out_status_d = STATUS_OK;
        out_offset_d = (func_q == FUNC_ALLOC) ? (best_q + OFF_W'(4)) : '0;
      end
      DP_OUT_FAIL: begin
        out_status_d = STATUS_FAIL;
        out_offset_d = '0;
      end
      default: ;
    endcase
  end

  // Heap memory, one access per cycle, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr[WADDR_W+1:2]] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr[WADDR_W+1:2]];
    end
  end

  // Walk and result registers
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    hdr_q        <= hdr_d;
    best_q       <= best_d;
    need_q       <= need_d;
    bsize_q      <= bsize_d;
    bhdr_q       <= bhdr_d;
    nv_q         <= nv_d;
    h_q          <= h_d;
    ps_q         <= ps_d;
    func_q       <= func_d;
    out_status_q <= out_status_d;
    out_offset_q <= out_offset_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  assign out_status_o = out_status_q;
  assign out_offset_o = out_offset_q;

endmodule

[sv/bfha_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the allocator: heap set-up after reset, list walk and update sequencing.
// Depends on bfha_pkg; steers bfha_dp with dp_cmd_t and reads dp_status_t.
module bfha_ctrl import bfha_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [19:0] {
    ST_INIT0  = 20'h00001,
    ST_INIT1  = 20'h00002,
    ST_INIT2  = 20'h00004,
    ST_IDLE   = 20'h00008,
    ST_A_RD   = 20'h00010,
    ST_A_CHK  = 20'h00020,
    ST_A_DEC  = 20'h00040,
    ST_A_NXT  = 20'h00080,
    ST_A_W1   = 20'h00100,
    ST_A_W2   = 20'h00200,
    ST_A_W3   = 20'h00400,
    ST_F_RD   = 20'h00800,
    ST_F_CHK  = 20'h01000,
    ST_F_NX   = 20'h02000,
    ST_F_NV   = 20'h04000,
    ST_F_PS   = 20'h08000,
    ST_F_W1   = 20'h10000,
    ST_F_W2   = 20'h20000,
    ST_F_W3   = 20'h40000,
    ST_DONE   = 20'h80000
  } state_e;

  state_e state_q, state_d;
  logic   fail_q, fail_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and command
  always_comb begin
    state_d     = state_q;
    fail_d      = fail_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op    = DP_NOP;
    unique case (state_q)
      ST_INIT0: begin
        cmd_o.op = DP_INIT_HDR;
        state_d  = ST_INIT1;
      end
      ST_INIT1: begin
        cmd_o.op = DP_INIT_FTR;
        state_d  = ST_INIT2;
      end
      ST_INIT2: begin
        cmd_o.op = DP_INIT_END;
        state_d  = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_START;
          fail_d   = 1'b0;
          if (status_i.in_func == FUNC_ALLOC) begin
            if (status_i.req_zero) begin
              fail_d  = 1'b1;
              state_d = ST_DONE;
            end else begin
              state_d = ST_A_RD;
            end
          end else begin
            if (status_i.free_bad) begin
              fail_d  = 1'b1;
              state_d = ST_DONE;
            end else begin
              state_d = ST_F_RD;
            end
          end
        end
      end
      // allocate: best-fit walk
      ST_A_RD: begin
        if (status_i.pos_end) begin
          state_d = ST_A_DEC;
        end else begin
          cmd_o.op = DP_RD_POS;
          state_d  = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (status_i.hstop) begin
          state_d = ST_A_DEC;
        end else begin
          cmd_o.op = DP_ALLOC_STEP;
          state_d  = ST_A_RD;
        end
      end
      ST_A_DEC: begin
        if (!status_i.found) begin
          fail_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.op = DP_RD_NXT;
          state_d  = ST_A_NXT;
        end
      end
      ST_A_NXT: begin
        cmd_o.op = DP_LATCH_NV;
        state_d  = ST_A_W1;
      end
      ST_A_W1: begin
        cmd_o.op = DP_AW1;
        state_d  = ST_A_W2;
      end
      ST_A_W2: begin
        cmd_o.op = DP_AW2;
        state_d  = status_i.split ? ST_A_W3 : ST_DONE;
      end
      ST_A_W3: begin
        cmd_o.op = DP_AW3;
        state_d  = ST_DONE;
      end
      // free: locate the header, then coalesce
      ST_F_RD: begin
        if (status_i.pos_end) begin
          fail_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.op = DP_RD_POS;
          state_d  = ST_F_CHK;
        end
      end
      ST_F_CHK: begin
        priority if (status_i.hit) begin
          if (status_i.h_used) begin
            cmd_o.op = DP_LATCH_H;
            state_d  = ST_F_NX;
          end else begin
            fail_d  = 1'b1;
            state_d = ST_DONE;
          end
        end else if (status_i.hstop || status_i.past) begin
          fail_d  = 1'b1;
          state_d = ST_DONE;
        end else begin
          cmd_o.op = DP_FREE_STEP;
          state_d  = ST_F_RD;
        end
      end
      ST_F_NX: begin
        cmd_o.op = DP_RD_FNX;
        state_d  = ST_F_NV;
      end
      ST_F_NV: begin
        cmd_o.op = DP_NV_RDPS;
        state_d  = ST_F_PS;
      end
      ST_F_PS: begin
        cmd_o.op = DP_LATCH_PS;
        state_d  = ST_F_W1;
      end
      ST_F_W1: begin
        cmd_o.op = DP_FW1;
        state_d  = ST_F_W2;
      end
      ST_F_W2: begin
        cmd_o.op = DP_FW2;
        state_d  = status_i.nx_keep ? ST_F_W3 : ST_DONE;
      end
      ST_F_W3: begin
        cmd_o.op = DP_FW3;
        state_d  = ST_DONE;
      end
      // hand the word to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = fail_q ? DP_OUT_FAIL : DP_OUT_OK;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_INIT0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT0;
      fail_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fail_q      <= fail_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/best_fit_heap_allocator_unit.sv]
`timescale 1ns / 1ps
// Best-fit heap allocator over a 4 KiB implicit block list held in a 1024 x 16 memory.
// Requests come in on req_i (func 0 allocate request_bytes, func 1 free free_offset); each
// request gives exactly one word on rsp_o: status 0 success / 1 failure, and for a
// successful allocate the payload offset in granted_offset (0 otherwise).
// One request is worked on at a time; req_i.ready is high only while the block is idle.
// The time to a response is set by the list walk through the single-port heap memory,
// which reads one block header after another: an allocate walks the whole list, a free
// walks up to and including the freed block, and a rejected size or a bad offset is
// answered without a walk.
// The response sits in an output register, so a stalled receiver does not hold off the
// next request; only the following result waits until rsp_o has been taken.
// After reset the block writes the initial free block, its footer and the end mark, with
// req_i.ready low; other memory words stay unwritten, and their values are never used.
// Depends on bfha_pkg, bfha_req_if/bfha_rsp_if, bfha_ctrl and bfha_dp.
module best_fit_heap_allocator_unit import bfha_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  bfha_req_if.sink      req_i,
  bfha_rsp_if.source    rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       out_valid;
  logic       out_status;
  logic [OFF_W-1:0] out_offset;

  // Sequencing
  bfha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Heap memory and arithmetic
  bfha_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .func_i          (req_i.func),
    .request_bytes_i (req_i.request_bytes),
    .free_offset_i   (req_i.free_offset),
    .status_o        (status),
    .out_status_o    (out_status),
    .out_offset_o    (out_offset)
  );

  assign rsp_o.valid          = out_valid;
  assign rsp_o.status         = out_status;
  assign rsp_o.granted_offset = out_offset;

endmodule
